[rtl/assert_macros.svh]
// assertion macros for the scheduler rtl
// no dependencies; included by files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/ppsch_pkg.sv]
// shared types for the preemptive priority scheduler
// no dependencies
package ppsch_pkg;

   typedef enum logic [1:0] {
      OP_LOAD = 2'd0,
      OP_TICK = 2'd1,
      OP_READ = 2'd2,
      OP_NOP  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_FOLD,
      S_EXEC,
      S_RESP
   } state_type;

   typedef struct packed {
      logic capture;
      logic fold;
      logic exec;
      logic respond;
   } cmd_type;

   localparam int OP_W    = 2;
   localparam int SLOT_W  = 4;
   localparam int TIME_W  = 16;
   localparam int PRIO_W  = 8;

endpackage

[rtl/ppsch_ctrl.sv]
// controller state machine of the scheduler
// depends on ppsch_pkg; drives datapath commands and the handshake flags
module ppsch_ctrl #(
   parameter int SLOTS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ppsch_pkg::OP_W-1:0]        req_op,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output ppsch_pkg::cmd_type                cmd
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int LVL_W = $clog2(IDX_W + 1);

   ppsch_pkg::state_type state_ff, state_in;
   logic [LVL_W-1:0]     level_ff, level_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 accept;
   logic                 out_free;

   assign accept    = req_valid && (state_ff == ppsch_pkg::S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ppsch_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ppsch_pkg::S_IDLE;
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      level_in     = level_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         ppsch_pkg::S_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               level_in    = '0;
               if (ppsch_pkg::op_type'(req_op) == ppsch_pkg::OP_TICK) begin
                  state_in = ppsch_pkg::S_FOLD;
               end else begin
                  state_in = ppsch_pkg::S_EXEC;
               end
            end
         end
         ppsch_pkg::S_FOLD: begin
            cmd.fold = 1'b1;
            level_in = level_ff + 1'b1;
            if (level_ff == LVL_W'(IDX_W - 1)) begin
               state_in = ppsch_pkg::S_EXEC;
            end
         end
         ppsch_pkg::S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ppsch_pkg::S_RESP;
         end
         ppsch_pkg::S_RESP: begin
            if (out_free) begin
               cmd.respond  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ppsch_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ppsch_pkg::S_IDLE;
         end
      endcase
   end

endmodule

[rtl/ppsch_datapath.sv]
// slot table, registered priority tree and result registers of the scheduler
// depends on ppsch_pkg; sequenced by ppsch_ctrl commands
module ppsch_datapath #(
   parameter int SLOTS     = 16,
   parameter int TIME_BITS = 16,
   parameter int PRIO_BITS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ppsch_pkg::cmd_type                cmd,
   input  logic [ppsch_pkg::OP_W-1:0]        req_op,
   input  logic [ppsch_pkg::SLOT_W-1:0]      req_slot,
   input  logic [ppsch_pkg::TIME_W-1:0]      req_arrival,
   input  logic [ppsch_pkg::PRIO_W-1:0]      req_prio,
   input  logic [ppsch_pkg::TIME_W-1:0]      req_burst,
   output logic [ppsch_pkg::SLOT_W-1:0]      rsp_selected,
   output logic                              rsp_idle,
   output logic                              rsp_all_done,
   output logic [ppsch_pkg::TIME_W-1:0]      rsp_wait_count,
   output logic [ppsch_pkg::TIME_W-1:0]      rsp_time_now
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int POW2  = 1 << IDX_W;
   localparam int HALF  = POW2 / 2;

   // slot table
   logic                 valid_ff  [SLOTS];
   logic [TIME_BITS-1:0] arrival_ff[SLOTS];
   logic [PRIO_BITS-1:0] prio_ff   [SLOTS];
   logic [TIME_BITS-1:0] remain_ff [SLOTS];
   logic [TIME_BITS-1:0] wait_ff   [SLOTS];
   logic [TIME_BITS-1:0] time_ff;

   // captured request
   ppsch_pkg::op_type           op_ff;
   logic [ppsch_pkg::SLOT_W-1:0] slot_ff;
   logic [ppsch_pkg::TIME_W-1:0] arr_req_ff;
   logic [ppsch_pkg::PRIO_W-1:0] prio_req_ff;
   logic [ppsch_pkg::TIME_W-1:0] burst_req_ff;
   logic [TIME_BITS-1:0]         before_ff;

   // priority tree
   logic                 cand_ok_ff  [POW2];
   logic [PRIO_BITS-1:0] cand_prio_ff[POW2];
   logic [IDX_W-1:0]     cand_idx_ff [POW2];
   logic                 fold_ok     [HALF];
   logic [PRIO_BITS-1:0] fold_prio   [HALF];
   logic [IDX_W-1:0]     fold_idx    [HALF];

   // pending result
   logic [IDX_W-1:0]     res_sel_ff;
   logic                 res_idle_ff;
   logic [TIME_BITS-1:0] res_wait_ff;

   // output register
   logic [ppsch_pkg::SLOT_W-1:0] out_sel_ff;
   logic                         out_idle_ff;
   logic                         out_done_ff;
   logic [ppsch_pkg::TIME_W-1:0] out_wait_ff;
   logic [ppsch_pkg::TIME_W-1:0] out_time_ff;

   logic                 elig[POW2];
   logic                 all_done;
   logic [IDX_W-1:0]     slot_idx;
   logic                 slot_ok;
   logic                 win_ok;
   logic [IDX_W-1:0]     win_idx;

   assign slot_idx = IDX_W'(32'(slot_ff));
   assign slot_ok  = (32'(slot_ff) < SLOTS);
   assign win_ok   = cand_ok_ff[0];
   assign win_idx  = cand_idx_ff[0];

   always_comb begin
      for (int i = 0; i < POW2; i++) begin
         elig[i] = 1'b0;
      end
      for (int i = 0; i < SLOTS; i++) begin
         elig[i] = valid_ff[i] && (arrival_ff[i] <= time_ff) && (remain_ff[i] != '0);
      end
   end

   always_comb begin
      all_done = 1'b1;
      for (int i = 0; i < SLOTS; i++) begin
         if (valid_ff[i] && (remain_ff[i] != '0)) begin
            all_done = 1'b0;
         end
      end
   end

   // pair compare, the lower index wins a tie
   always_comb begin
      for (int i = 0; i < HALF; i++) begin
         if (cand_ok_ff[2*i+1] &&
             (!cand_ok_ff[2*i] || (cand_prio_ff[2*i+1] < cand_prio_ff[2*i]))) begin
            fold_ok[i]   = cand_ok_ff[2*i+1];
            fold_prio[i] = cand_prio_ff[2*i+1];
            fold_idx[i]  = cand_idx_ff[2*i+1];
         end else begin
            fold_ok[i]   = cand_ok_ff[2*i];
            fold_prio[i] = cand_prio_ff[2*i];
            fold_idx[i]  = cand_idx_ff[2*i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            valid_ff[i] <= 1'b0;
         end
         time_ff <= '0;
      end else if (cmd.exec) begin
         case (op_ff)
            ppsch_pkg::OP_LOAD: begin
               if (slot_ok) begin
                  valid_ff[slot_idx] <= 1'b1;
                  time_ff            <= '0;
               end
            end
            ppsch_pkg::OP_TICK: begin
               if (time_ff != '1) begin
                  time_ff <= time_ff + 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         case (op_ff)
            ppsch_pkg::OP_LOAD: begin
               if (slot_ok) begin
                  arrival_ff[slot_idx] <= TIME_BITS'(arr_req_ff);
                  prio_ff[slot_idx]    <= PRIO_BITS'(prio_req_ff);
                  remain_ff[slot_idx]  <= TIME_BITS'(burst_req_ff);
                  wait_ff[slot_idx]    <= '0;
               end
            end
            ppsch_pkg::OP_TICK: begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (elig[i]) begin
                     if (win_ok && (win_idx == IDX_W'(i))) begin
                        remain_ff[i] <= remain_ff[i] - 1'b1;
                     end else if (wait_ff[i] != '1) begin
                        wait_ff[i] <= wait_ff[i] + 1'b1;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff        <= ppsch_pkg::op_type'(req_op);
         slot_ff      <= req_slot;
         arr_req_ff   <= req_arrival;
         prio_req_ff  <= req_prio;
         burst_req_ff <= req_burst;
         before_ff    <= time_ff;
         for (int i = 0; i < POW2; i++) begin
            cand_ok_ff[i]  <= elig[i];
            cand_idx_ff[i] <= IDX_W'(i);
         end
         for (int i = 0; i < SLOTS; i++) begin
            cand_prio_ff[i] <= prio_ff[i];
         end
      end else if (cmd.fold) begin
         for (int i = 0; i < HALF; i++) begin
            cand_ok_ff[i]   <= fold_ok[i];
            cand_prio_ff[i] <= fold_prio[i];
            cand_idx_ff[i]  <= fold_idx[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         res_sel_ff  <= '0;
         res_idle_ff <= 1'b0;
         res_wait_ff <= '0;
         case (op_ff)
            ppsch_pkg::OP_TICK: begin
               res_idle_ff <= !win_ok;
               if (win_ok) begin
                  res_sel_ff <= win_idx;
               end
            end
            ppsch_pkg::OP_READ: begin
               if (slot_ok && valid_ff[slot_idx]) begin
                  res_wait_ff <= wait_ff[slot_idx];
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         out_sel_ff  <= ppsch_pkg::SLOT_W'(32'(res_sel_ff));
         out_idle_ff <= res_idle_ff;
         out_done_ff <= all_done;
         out_wait_ff <= ppsch_pkg::TIME_W'(64'(res_wait_ff));
         out_time_ff <= ppsch_pkg::TIME_W'(64'(before_ff));
      end
   end

   assign rsp_selected   = out_sel_ff;
   assign rsp_idle       = out_idle_ff;
   assign rsp_all_done   = out_done_ff;
   assign rsp_wait_count = out_wait_ff;
   assign rsp_time_now   = out_time_ff;

endmodule

[rtl/preemptive_priority_scheduler.sv]
// channel  dir  ports                                        handshake
// req      in   op, slot, arrival, prio, burst               req_valid / req_stall
// rsp      out  selected, idle, all_done, wait_count, time_now  rsp_valid / rsp_stall
//
// a tick takes the request and the eligible set, makes ceil(log2(SLOTS)) passes of
// the registered priority tree, updates the slots and then writes the output register;
// load, read and no-op requests skip the tree passes
// synchronous reset clears slot valid bits, the clock and the controller
// a new request is taken while a result waits under rsp_stall; only the last step waits
// top level; depends on ppsch_pkg, ppsch_ctrl, ppsch_datapath and assert_macros.svh
`include "assert_macros.svh"

module preemptive_priority_scheduler #(
   parameter int SLOTS     = 16,
   parameter int TIME_BITS = 16,
   parameter int PRIO_BITS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ppsch_pkg::OP_W-1:0]        req_op,
   input  logic [ppsch_pkg::SLOT_W-1:0]      req_slot,
   input  logic [ppsch_pkg::TIME_W-1:0]      req_arrival,
   input  logic [ppsch_pkg::PRIO_W-1:0]      req_prio,
   input  logic [ppsch_pkg::TIME_W-1:0]      req_burst,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ppsch_pkg::SLOT_W-1:0]      rsp_selected,
   output logic                              rsp_idle,
   output logic                              rsp_all_done,
   output logic [ppsch_pkg::TIME_W-1:0]      rsp_wait_count,
   output logic [ppsch_pkg::TIME_W-1:0]      rsp_time_now
);

   ppsch_pkg::cmd_type cmd;

   ppsch_ctrl #(
      .SLOTS (SLOTS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   ppsch_datapath #(
      .SLOTS     (SLOTS),
      .TIME_BITS (TIME_BITS),
      .PRIO_BITS (PRIO_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_op         (req_op),
      .req_slot       (req_slot),
      .req_arrival    (req_arrival),
      .req_prio       (req_prio),
      .req_burst      (req_burst),
      .rsp_selected   (rsp_selected),
      .rsp_idle       (rsp_idle),
      .rsp_all_done   (rsp_all_done),
      .rsp_wait_count (rsp_wait_count),
      .rsp_time_now   (rsp_time_now)
   );

   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall,
      "request accepted but block not busy next cycle")
   `ASSERT_SAME(a_idle_no_select, clock, reset, rsp_valid && rsp_idle,
      rsp_selected == '0 && rsp_wait_count == '0, "idle result carries a slot or wait count")
   `ASSERT_ALWAYS(a_one_command, clock, reset, $onehot0(cmd),
      "more than one datapath command in a cycle")
   `ASSERT_NEXT(a_respond_sets_valid, clock, reset, cmd.respond, rsp_valid,
      "result written without valid")

endmodule
